// ===== rtl/core/oue_pkg.sv =====
// Shared types, constants and saturation helper of the optimizer update engine.
package oue_pkg;

  localparam int unsigned ELEMENT_COUNT = 4096;
  localparam int unsigned FRACTION_BITS = 24;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned LR_W          = 25;
  localparam int unsigned SCALE_W       = 32;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam int unsigned OMB_W  = ((FRACTION_BITS > LR_W) ? FRACTION_BITS : LR_W) + 2;
  localparam int unsigned PL_W   = WORD_W + LR_W + 1;
  localparam int unsigned PO_W   = WORD_W + OMB_W;
  localparam int unsigned PG_W   = 2 * WORD_W;
  localparam int unsigned PS_W   = WORD_W + SCALE_W + 1;
  localparam int unsigned RAD_W  = 2 * ((WORD_W - 1 + FRACTION_BITS + 1) / 2);
  localparam int unsigned SQ_STEPS = RAD_W / 2;
  localparam int unsigned DIVD_W = WORD_W - 1 + LR_W;
  localparam int unsigned BIAS_SHIFT = 16;

  localparam logic [LR_W-1:0]    LR_RESET    = LR_W'(1678);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    MODE_SGD      = 2'd0,
    MODE_MOMENTUM = 2'd1,
    MODE_ADAM     = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_LEARNING_RATE = 3'd1,
    CFG_MOMENTUM      = 3'd2,
    CFG_FIRST_DECAY   = 3'd3,
    CFG_SECOND_DECAY  = 3'd4,
    CFG_FIRST_BIAS    = 3'd5,
    CFG_SECOND_BIAS   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]         element_index;
    logic signed [WORD_W-1:0] weight_value;
    logic signed [WORD_W-1:0] gradient_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_weight;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic signed [PS_W-1:0]   p_h1;
    logic signed [PL_W-1:0]   p_hl;
    logic signed [WORD_W-1:0] w;
    sat_t                     pre;
    logic                     adam;
  } tail_in_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    r.hit = 1'b0;
    r.val = x[WORD_W-1:0];
    if (x > S32_MAX) begin
      r.hit = 1'b1;
      r.val = S32_MAX[WORD_W-1:0];
    end else if (x < S32_MIN) begin
      r.hit = 1'b1;
      r.val = S32_MIN[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/oue_adam_tail.sv =====
// Square root and division pipeline that finishes the Adam step and holds the result.
module oue_adam_tail (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  oue_pkg::tail_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output oue_pkg::out_item_t out_data_o
);
  import oue_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0]         rad;
    logic [SQ_STEPS-1:0]      root;
    logic [SQ_STEPS+1:0]      rem;
    logic [DIVD_W-1:0]        mag;
    logic                     neg;
    logic signed [WORD_W-1:0] w;
    sat_t                     pre;
    logic                     adam;
  } sq_t;

  typedef struct packed {
    logic [SQ_STEPS:0]        d;
    logic [SQ_STEPS:0]        rem;
    logic [DIVD_W-1:0]        quo;
    logic [DIVD_W-1:0]        dvd;
    logic                     neg;
    logic signed [WORD_W-1:0] w;
    sat_t                     pre;
    logic                     adam;
  } div_t;

  sq_t  sq_q  [0:SQ_STEPS];
  sq_t  sq_d  [0:SQ_STEPS];
  div_t div_q [0:DIVD_W];
  div_t div_d [0:DIVD_W];
  logic [SQ_STEPS:0] sq_v_q, sq_adv;
  logic [DIVD_W:0]   div_v_q, div_adv;
  logic out_v_q, out_adv;
  sat_t out_q, out_d;

  logic signed [PS_W-1:0] h1_full;
  logic [WORD_W-2:0]      h1;
  logic [PL_W-1:0]        hl_abs;

  assign h1_full = in_data_i.p_h1 >>> BIAS_SHIFT;
  assign h1 = h1_full[PS_W-1] ? '0 :
              (|h1_full[PS_W-2:WORD_W-1]) ? '1 : h1_full[WORD_W-2:0];
  assign hl_abs = in_data_i.p_hl[PL_W-1] ? PL_W'(-in_data_i.p_hl) : PL_W'(in_data_i.p_hl);

  always_comb begin
    sq_d[0].rad  = RAD_W'({h1, {FRACTION_BITS{1'b0}}});
    sq_d[0].root = '0;
    sq_d[0].rem  = '0;
    sq_d[0].mag  = hl_abs[DIVD_W-1:0];
    sq_d[0].neg  = in_data_i.p_hl[PL_W-1];
    sq_d[0].w    = in_data_i.w;
    sq_d[0].pre  = in_data_i.pre;
    sq_d[0].adam = in_data_i.adam;
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [SQ_STEPS+3:0] sh, tr;
    always_comb begin
      sh = {sq_q[k-1].rem, sq_q[k-1].rad[RAD_W-1 -: 2]};
      tr = {2'b00, sq_q[k-1].root, 2'b01};
      sq_d[k] = sq_q[k-1];
      sq_d[k].rad = {sq_q[k-1].rad[RAD_W-3:0], 2'b00};
      if (sh >= tr) begin
        sq_d[k].rem  = (SQ_STEPS+2)'(sh - tr);
        sq_d[k].root = {sq_q[k-1].root[SQ_STEPS-2:0], 1'b1};
      end else begin
        sq_d[k].rem  = (SQ_STEPS+2)'(sh);
        sq_d[k].root = {sq_q[k-1].root[SQ_STEPS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    div_d[0].d    = (SQ_STEPS+1)'(sq_q[SQ_STEPS].root) + (SQ_STEPS+1)'(1);
    div_d[0].rem  = '0;
    div_d[0].quo  = '0;
    div_d[0].dvd  = sq_q[SQ_STEPS].mag;
    div_d[0].neg  = sq_q[SQ_STEPS].neg;
    div_d[0].w    = sq_q[SQ_STEPS].w;
    div_d[0].pre  = sq_q[SQ_STEPS].pre;
    div_d[0].adam = sq_q[SQ_STEPS].adam;
  end

  for (genvar k = 1; k <= DIVD_W; k++) begin : g_div
    logic [SQ_STEPS+1:0] r;
    always_comb begin
      r = {div_q[k-1].rem, div_q[k-1].dvd[DIVD_W-1]};
      div_d[k] = div_q[k-1];
      div_d[k].dvd = {div_q[k-1].dvd[DIVD_W-2:0], 1'b0};
      if (r >= {1'b0, div_q[k-1].d}) begin
        div_d[k].rem = (SQ_STEPS+1)'(r - {1'b0, div_q[k-1].d});
        div_d[k].quo = {div_q[k-1].quo[DIVD_W-2:0], 1'b1};
      end else begin
        div_d[k].rem = (SQ_STEPS+1)'(r);
        div_d[k].quo = {div_q[k-1].quo[DIVD_W-2:0], 1'b0};
      end
    end
  end

  logic signed [63:0] quo_s, diff;
  always_comb begin
    quo_s = $signed(64'(div_q[DIVD_W].quo));
    if (div_q[DIVD_W].neg) begin
      quo_s = -quo_s;
    end
    diff = 64'(div_q[DIVD_W].w) - quo_s;
    out_d = div_q[DIVD_W].adam ? sat32(diff) : div_q[DIVD_W].pre;
  end

  assign out_adv = !out_v_q || out_ready_i;

  for (genvar k = 0; k <= DIVD_W; k++) begin : g_div_ctl
    if (k == DIVD_W) begin : g_last
      assign div_adv[k] = !div_v_q[k] || out_adv;
    end else begin : g_mid
      assign div_adv[k] = !div_v_q[k] || div_adv[k+1];
    end
    always_ff @(posedge clk_i) begin
      if (div_adv[k]) begin
        div_q[k] <= div_d[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k] <= 1'b0;
      end else if (div_adv[k]) begin
        div_v_q[k] <= (k == 0) ? sq_v_q[SQ_STEPS] : div_v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  for (genvar k = 0; k <= SQ_STEPS; k++) begin : g_sq_ctl
    if (k == SQ_STEPS) begin : g_last
      assign sq_adv[k] = !sq_v_q[k] || div_adv[0];
    end else begin : g_mid
      assign sq_adv[k] = !sq_v_q[k] || sq_adv[k+1];
    end
    always_ff @(posedge clk_i) begin
      if (sq_adv[k]) begin
        sq_q[k] <= sq_d[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (sq_adv[k]) begin
        sq_v_q[k] <= (k == 0) ? in_valid_i : sq_v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= div_v_q[DIVD_W];
    end
  end

  assign in_ready_o            = sq_adv[0];
  assign out_valid_o           = out_v_q;
  assign out_data_o.new_weight = out_q.val;
  assign out_data_o.saturated  = out_q.hit;

endmodule

// ===== rtl/core/optimizer_update_engine.sv =====
// Weights and gradients are Q8.24; the front stages feed the Adam square-root tail.
// Throughput: one transfer per cycle unless stalled; an element index already in the
// first five stages holds off the input until that element's store update is written.
// Reset clears the control state, then a clearing pass zeroes the velocity and
// moment memories, one entry per cycle, before the first input transfer.
// Top level of the optimizer update engine: configuration, stores and front stages.
module optimizer_update_engine #(
  parameter int unsigned ElementCount = oue_pkg::ELEMENT_COUNT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  oue_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output oue_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [oue_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [oue_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import oue_pkg::*;

  localparam int unsigned AW = (ElementCount > 1) ? $clog2(ElementCount) : 1;
  localparam logic [FRACTION_BITS+1:0] QOne = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

  logic [1:0]         mode_q;
  logic [LR_W-1:0]    lr_q, mu_q, b0_q, b1_q;
  logic [SCALE_W-1:0] s0_q, s1_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SGD;
      lr_q   <= LR_RESET;
      mu_q   <= '0;
      b0_q   <= '0;
      b1_q   <= '0;
      s0_q   <= SCALE_RESET;
      s1_q   <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:          mode_q <= cfg_data_i[1:0];
        CFG_LEARNING_RATE: lr_q   <= cfg_data_i[LR_W-1:0];
        CFG_MOMENTUM:      mu_q   <= cfg_data_i[LR_W-1:0];
        CFG_FIRST_DECAY:   b0_q   <= cfg_data_i[LR_W-1:0];
        CFG_SECOND_DECAY:  b1_q   <= cfg_data_i[LR_W-1:0];
        CFG_FIRST_BIAS:    s0_q   <= cfg_data_i[SCALE_W-1:0];
        CFG_SECOND_BIAS:   s1_q   <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [AW-1:0] idx_in;

  if (ElementCount >= (1 << IDX_W)) begin : g_idx_full
    assign idx_in = AW'(in_data_i.element_index);
  end else if (ElementCount == 1) begin : g_idx_one
    assign idx_in = '0;
  end else if ((ElementCount & (ElementCount - 1)) == 0) begin : g_idx_pow2
    assign idx_in = in_data_i.element_index[AW-1:0];
  end else begin : g_idx_recip
    localparam longint unsigned Recip = ((64'd1 << 24) + ElementCount - 1) / ElementCount;
    logic [36:0]        prod;
    logic [12:0]        quo;
    logic [25:0]        back;
    logic signed [26:0] rem;
    assign prod   = 37'(in_data_i.element_index) * 37'(Recip);
    assign quo    = prod[36:24];
    assign back   = 26'(quo) * 26'(ElementCount);
    assign rem    = $signed({15'b0, in_data_i.element_index}) - $signed({1'b0, back});
    assign idx_in = rem[26] ? AW'(rem + 27'(ElementCount)) : AW'(rem);
  end

  logic [WORD_W-1:0] vel_mem [ElementCount];
  logic [WORD_W-1:0] m0_mem  [ElementCount];
  logic [WORD_W-1:0] m1_mem  [ElementCount];

  logic          clearing_q;
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(ElementCount - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic adv1, adv2, adv3, adv4, adv5, adv6;
  logic tail_ready, in_acc, hazard;

  logic [AW-1:0] s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q, s5_idx_q;
  logic signed [WORD_W-1:0] s1_w_q, s2_w_q, s3_w_q, s4_w_q, s5_w_q, s6_w_q;
  logic signed [WORD_W-1:0] s1_g_q;
  logic signed [WORD_W-1:0] vel_rd_q, m0_rd_q, m1_rd_q;

  logic signed [PL_W-1:0]  p_vmu_d, p_vmu_q, p_glr_d, p_glr_q, p_m0b0_d, p_m0b0_q;
  logic signed [PO_W-1:0]  p_gone_d, p_gone_q;
  logic signed [PG_W-1:0]  p_gg_d, p_gg_q;
  logic signed [WORD_W-1:0] s2_m1_q;
  logic signed [OMB_W-1:0] omb0, omb1;

  sat_t v_sat, m0_sat, g2_sat, sgd_d;
  logic signed [WORD_W-1:0] vel3_q, m0_3_q, g2_q, s3_m1_q;
  sat_t sgd_q;

  logic signed [PL_W-1:0]  p_m1b1_d, p_m1b1_q;
  logic signed [PO_W-1:0]  p_g2one_d, p_g2one_q;
  logic signed [PS_W-1:0]  p_h0_d, p_h0_q;
  logic signed [WORD_W-1:0] vel4_q, m0_4_q;
  sat_t pre_d, pre4_q, pre5_q, pre6_q;

  sat_t m1_sat, h0_sat;
  logic signed [WORD_W-1:0] v5_val_q, m0_5_q, m1_5_q, h0_q;

  logic signed [PS_W-1:0] p_h1_d, p_h1_q;
  logic signed [PL_W-1:0] p_hl_d, p_hl_q;

  assign hazard = (v1_q && s1_idx_q == idx_in) || (v2_q && s2_idx_q == idx_in) ||
                  (v3_q && s3_idx_q == idx_in) || (v4_q && s4_idx_q == idx_in) ||
                  (v5_q && s5_idx_q == idx_in);

  assign adv6 = !v6_q || tail_ready;
  assign adv5 = !v5_q || adv6;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_ready_o = adv1 && !clearing_q && !hazard;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_acc;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
      if (adv6) v6_q <= v5_q;
    end
  end

  logic          wr_store;
  logic          vel_we, mom_we;
  logic [AW-1:0] wr_addr;

  assign wr_store = v5_q && adv6;
  assign vel_we   = clearing_q || (wr_store && mode_q == MODE_MOMENTUM);
  assign mom_we   = clearing_q || (wr_store && mode_q == MODE_ADAM);
  assign wr_addr  = clearing_q ? clr_q : s5_idx_q;

  always_ff @(posedge clk_i) begin
    if (vel_we) begin
      vel_mem[wr_addr] <= clearing_q ? '0 : v5_val_q;
    end
    if (mom_we) begin
      m0_mem[wr_addr] <= clearing_q ? '0 : m0_5_q;
      m1_mem[wr_addr] <= clearing_q ? '0 : m1_5_q;
    end
    if (in_acc) begin
      vel_rd_q <= vel_mem[idx_in];
      m0_rd_q  <= m0_mem[idx_in];
      m1_rd_q  <= m1_mem[idx_in];
    end
  end

  assign omb0 = $signed(OMB_W'(QOne)) - $signed(OMB_W'(b0_q));
  assign omb1 = $signed(OMB_W'(QOne)) - $signed(OMB_W'(b1_q));

  assign p_vmu_d  = vel_rd_q * $signed({1'b0, mu_q});
  assign p_glr_d  = s1_g_q * $signed({1'b0, lr_q});
  assign p_m0b0_d = m0_rd_q * $signed({1'b0, b0_q});
  assign p_gone_d = s1_g_q * omb0;
  assign p_gg_d   = s1_g_q * s1_g_q;

  assign v_sat  = sat32(64'(p_vmu_q >>> FRACTION_BITS) - 64'(p_glr_q >>> FRACTION_BITS));
  assign m0_sat = sat32(64'(p_m0b0_q >>> FRACTION_BITS) + 64'(p_gone_q >>> FRACTION_BITS));
  assign g2_sat = sat32(64'(p_gg_q >>> FRACTION_BITS));
  assign sgd_d  = sat32(64'(s2_w_q) - 64'(p_glr_q >>> FRACTION_BITS));

  assign p_m1b1_d  = s3_m1_q * $signed({1'b0, b1_q});
  assign p_g2one_d = g2_q * omb1;
  assign p_h0_d    = m0_3_q * $signed({1'b0, s0_q});

  always_comb begin
    case (mode_q)
      MODE_SGD:      pre_d = sgd_q;
      MODE_MOMENTUM: pre_d = sat32(64'(s3_w_q) + 64'(vel3_q));
      default: begin
        pre_d.hit = 1'b0;
        pre_d.val = s3_w_q;
      end
    endcase
  end

  assign m1_sat = sat32(64'(p_m1b1_q >>> FRACTION_BITS) + 64'(p_g2one_q >>> FRACTION_BITS));
  assign h0_sat = sat32(64'(p_h0_q >>> BIAS_SHIFT));

  assign p_h1_d = m1_5_q * $signed({1'b0, s1_q});
  assign p_hl_d = h0_q * $signed({1'b0, lr_q});

  always_ff @(posedge clk_i) begin
    if (adv1 && in_acc) begin
      s1_idx_q <= idx_in;
      s1_w_q   <= in_data_i.weight_value;
      s1_g_q   <= in_data_i.gradient_value;
    end
    if (adv2) begin
      s2_idx_q <= s1_idx_q;
      s2_w_q   <= s1_w_q;
      s2_m1_q  <= m1_rd_q;
      p_vmu_q  <= p_vmu_d;
      p_glr_q  <= p_glr_d;
      p_m0b0_q <= p_m0b0_d;
      p_gone_q <= p_gone_d;
      p_gg_q   <= p_gg_d;
    end
    if (adv3) begin
      s3_idx_q <= s2_idx_q;
      s3_w_q   <= s2_w_q;
      s3_m1_q  <= s2_m1_q;
      vel3_q   <= v_sat.val;
      m0_3_q   <= m0_sat.val;
      g2_q     <= g2_sat.val;
      sgd_q    <= sgd_d;
    end
    if (adv4) begin
      s4_idx_q  <= s3_idx_q;
      s4_w_q    <= s3_w_q;
      vel4_q    <= vel3_q;
      m0_4_q    <= m0_3_q;
      pre4_q    <= pre_d;
      p_m1b1_q  <= p_m1b1_d;
      p_g2one_q <= p_g2one_d;
      p_h0_q    <= p_h0_d;
    end
    if (adv5) begin
      s5_idx_q <= s4_idx_q;
      s5_w_q   <= s4_w_q;
      v5_val_q <= vel4_q;
      m0_5_q   <= m0_4_q;
      m1_5_q   <= m1_sat.val;
      h0_q     <= h0_sat.val;
      pre5_q   <= pre4_q;
    end
    if (adv6) begin
      s6_w_q <= s5_w_q;
      pre6_q <= pre5_q;
      p_h1_q <= p_h1_d;
      p_hl_q <= p_hl_d;
    end
  end

  tail_in_t tail_in;

  assign tail_in.p_h1 = p_h1_q;
  assign tail_in.p_hl = p_hl_q;
  assign tail_in.w    = s6_w_q;
  assign tail_in.pre  = pre6_q;
  assign tail_in.adam = (mode_q == MODE_ADAM);

  oue_adam_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v6_q),
    .in_ready_o  (tail_ready),
    .in_data_i   (tail_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
